>>> src/ptq_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ptq_pkg: shared types and constants of the periodic timer queue
// Holds sizes, command codes, the controller state type, the command and
// status structs between controller and datapath, and the wrap-aware compare.
// ---------------------------------------------------------------------------
package ptq_pkg;

   localparam int NUM_TIMERS = 16;
   localparam int TIME_BITS  = 48;
   localparam int ID_BITS    = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
   localparam int CNT_BITS   = $clog2(NUM_TIMERS + 1);
   localparam int US_PER_MS  = 1000;
   localparam int PROD_BITS  = 32 + 10;

   // Command codes carried on the input channel.
   typedef enum logic [1:0] {
      CMD_START = 2'd0,
      CMD_STOP  = 2'd1,
      CMD_TICK  = 2'd2,
      CMD_NONE  = 2'd3
   } command_type;

   // Controller states.
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DECODE,
      ST_MUL,
      ST_ADD,
      ST_INSERT,
      ST_REMOVE,
      ST_NOW,
      ST_CHECK
   } state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load_req;   // capture an accepted beat
      logic add_now;    // advance the time by the elapsed count
      logic mul_req;    // latch a started slot and its scaled period
      logic fire;       // emit the head and latch it for re-placement
      logic add_exp;    // form the new expiry
      logic insert;     // place the latched slot in the sorted chain
      logic remove;     // unlink the requested slot
      logic clr_armed;  // disarm the requested slot
   } dp_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      command_type     command;
      logic            start_ok;
      logic            stop_ok;
      logic            head_due;
      logic            rsp_busy;
      logic [CNT_BITS-1:0]   count;
      logic [NUM_TIMERS-1:0] armed;
   } dp_status_type;

   // True when a is at or after b, treating the time as a wrapping count.
   function automatic logic at_or_after(input logic [TIME_BITS-1:0] a,
                                        input logic [TIME_BITS-1:0] b);
      logic [TIME_BITS-1:0] diff;
      diff = a - b;
      return ~diff[TIME_BITS-1];
   endfunction

endpackage

>>> src/ptq_if.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ptq_req_if / ptq_rsp_if: valid-ready channels of the periodic timer queue
// A beat moves at a rising edge where valid and ready are both high.
// ---------------------------------------------------------------------------
interface ptq_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  command;
   logic [3:0]  timer_id;
   logic [31:0] period_ms;
   logic [15:0] elapsed_us;

   modport source (output valid, command, timer_id, period_ms, elapsed_us,
                   input ready);
   modport sink   (input valid, command, timer_id, period_ms, elapsed_us,
                   output ready);
endinterface

interface ptq_rsp_if;
   logic        valid;
   logic        ready;
   logic [3:0]  fired_timer;
   logic [47:0] fire_time;

   modport source (output valid, fired_timer, fire_time, input ready);
   modport sink   (input valid, fired_timer, fire_time, output ready);
endinterface

>>> src/periodic_timer_queue.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// periodic_timer_queue: sixteen periodic timers kept in order of expiry
// Start, stop and tick commands update a sorted chain of armed timers.
// ---------------------------------------------------------------------------
// Usage:
//   req_bus carries one command per beat: start (slot, period in ms), stop
//   (slot) or tick (elapsed microseconds). rsp_bus carries one beat per tick
//   whose earliest timer has expired: the slot and its expiry time.
//   The controller works on one command at a time and takes the next beat
//   only when it is back in its idle state. Each command steps through:
//     start : accept, decode, multiply, add, chain insert
//     stop  : accept, decode, chain remove
//     tick  : accept, decode, time add, head check; with a fire also
//             re-arm add, chain insert
//     ignored commands: accept, decode.
//   The multiply by 1000 and the expiry add are each registered; the
//   sorted chain updates all entries in parallel.
//   A fired beat appears the cycle after the head check and waits in an
//   output register; new commands are still taken while it waits. A second
//   fire stalls in the head check until the receiver takes the first.
//   Synchronous reset clears the time, the armed flags and the chain count;
//   no clearing pass is needed.
// ---------------------------------------------------------------------------
module periodic_timer_queue (
   input logic        clock,
   input logic        reset,
   ptq_req_if.sink    req_bus,
   ptq_rsp_if.source  rsp_bus
);

   ptq_pkg::dp_cmd_type    cmd;
   ptq_pkg::dp_status_type status;

   ptq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_ready (req_bus.ready),
      .status    (status),
      .cmd       (cmd)
   );

   ptq_dp u_dp (
      .clock           (clock),
      .reset           (reset),
      .req_command     (req_bus.command),
      .req_timer_id    (req_bus.timer_id),
      .req_period_ms   (req_bus.period_ms),
      .req_elapsed_us  (req_bus.elapsed_us),
      .cmd             (cmd),
      .status          (status),
      .rsp_valid       (rsp_bus.valid),
      .rsp_ready       (rsp_bus.ready),
      .rsp_fired_timer (rsp_bus.fired_timer),
      .rsp_fire_time   (rsp_bus.fire_time)
   );

   // The chain never holds more timers than there are slots.
   assert property (@(posedge clock) disable iff (reset)
      32'(status.count) <= ptq_pkg::NUM_TIMERS)
      else $error("chain count exceeds slot count");

   // Armed slots match chain entries, but for the one slot that is out of the
   // chain between arming or firing and its insertion.
   assert property (@(posedge clock) disable iff (reset)
      ($countones(status.armed) >= 32'(status.count)) &&
      ($countones(status.armed) <= 32'(status.count) + 1))
      else $error("armed flags and chain count disagree");

   // A fire is only issued when a due head can be delivered.
   assert property (@(posedge clock) disable iff (reset)
      cmd.fire |-> (status.head_due && !status.rsp_busy))
      else $error("fire without a due head or free output");

   // A fire is followed by the re-arm add.
   assert property (@(posedge clock) disable iff (reset)
      cmd.fire |=> cmd.add_exp)
      else $error("fired timer was not re-armed");

endmodule

>>> src/ptq_ctrl.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ptq_ctrl: controller of the periodic timer queue
// Steps each command through decode, multiply, add and chain update.
// ---------------------------------------------------------------------------
module ptq_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  ptq_pkg::dp_status_type status,
   output ptq_pkg::dp_cmd_type    cmd
);

   ptq_pkg::state_type state_ff, state_in;

   // State register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ptq_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ptq_pkg::ST_IDLE: begin
            if (req_valid) state_in = ptq_pkg::ST_DECODE;
         end
         ptq_pkg::ST_DECODE: begin
            case (status.command)
               ptq_pkg::CMD_START:
                  state_in = status.start_ok ? ptq_pkg::ST_MUL : ptq_pkg::ST_IDLE;
               ptq_pkg::CMD_STOP:
                  state_in = status.stop_ok ? ptq_pkg::ST_REMOVE : ptq_pkg::ST_IDLE;
               ptq_pkg::CMD_TICK: state_in = ptq_pkg::ST_NOW;
               default:           state_in = ptq_pkg::ST_IDLE;
            endcase
         end
         ptq_pkg::ST_MUL:    state_in = ptq_pkg::ST_ADD;
         ptq_pkg::ST_ADD:    state_in = ptq_pkg::ST_INSERT;
         ptq_pkg::ST_INSERT: state_in = ptq_pkg::ST_IDLE;
         ptq_pkg::ST_REMOVE: state_in = ptq_pkg::ST_IDLE;
         ptq_pkg::ST_NOW:    state_in = ptq_pkg::ST_CHECK;
         ptq_pkg::ST_CHECK: begin
            if (!status.head_due) state_in = ptq_pkg::ST_IDLE;
            else if (!status.rsp_busy) state_in = ptq_pkg::ST_ADD;
         end
         default: state_in = ptq_pkg::ST_IDLE;
      endcase
   end

   // Outputs.
   always_comb begin
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         ptq_pkg::ST_IDLE: begin
            req_ready    = 1'b1;
            cmd.load_req = req_valid;
         end
         ptq_pkg::ST_MUL:    cmd.mul_req = 1'b1;
         ptq_pkg::ST_ADD:    cmd.add_exp = 1'b1;
         ptq_pkg::ST_INSERT: cmd.insert = 1'b1;
         ptq_pkg::ST_REMOVE: begin
            cmd.remove    = 1'b1;
            cmd.clr_armed = 1'b1;
         end
         ptq_pkg::ST_NOW:    cmd.add_now = 1'b1;
         ptq_pkg::ST_CHECK: begin
            cmd.fire = status.head_due && !status.rsp_busy;
         end
         default: cmd = '0;
      endcase
   end

endmodule

>>> src/ptq_dp.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ptq_dp: datapath of the periodic timer queue
// A sorted shift chain of slot, expiry and period, the time count, the
// armed flags and the output register.
// ---------------------------------------------------------------------------
module ptq_dp (
   input  logic                   clock,
   input  logic                   reset,
   input  logic [1:0]             req_command,
   input  logic [3:0]             req_timer_id,
   input  logic [31:0]            req_period_ms,
   input  logic [15:0]            req_elapsed_us,
   input  ptq_pkg::dp_cmd_type    cmd,
   output ptq_pkg::dp_status_type status,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic [3:0]             rsp_fired_timer,
   output logic [47:0]            rsp_fire_time
);

   localparam int N  = ptq_pkg::NUM_TIMERS;
   localparam int TB = ptq_pkg::TIME_BITS;
   localparam int IB = ptq_pkg::ID_BITS;
   localparam int CB = ptq_pkg::CNT_BITS;

   // Captured request beat.
   logic [1:0]  cmd_ff;
   logic [3:0]  id_ff;
   logic [31:0] period_ff;
   logic [15:0] elapsed_ff;

   always_ff @(posedge clock) begin
      if (cmd.load_req) begin
         cmd_ff     <= req_command;
         id_ff      <= req_timer_id;
         period_ff  <= req_period_ms;
         elapsed_ff <= req_elapsed_us;
      end
   end

   logic [IB-1:0] req_slot;
   logic          id_in_range;
   assign req_slot    = IB'(id_ff);
   assign id_in_range = 32'(id_ff) < 32'(N);

   // Time count, armed flags and chain fill count.
   logic [TB-1:0] now_ff;
   logic [N-1:0]  armed_ff, armed_in;
   logic [CB-1:0] count_ff, count_in;

   // Sorted chain.
   logic [IB-1:0] slot_ff [N];
   logic [TB-1:0] exp_ff  [N];
   logic [31:0]   per_ff  [N];
   logic [IB-1:0] slot_in [N];
   logic [TB-1:0] exp_in  [N];
   logic [31:0]   per_in  [N];

   // Entry being placed and its arithmetic.
   logic [IB-1:0]            new_slot_ff;
   logic [31:0]              new_per_ff;
   logic [TB-1:0]            base_ff;
   logic [ptq_pkg::PROD_BITS-1:0] prod_ff;
   logic [TB-1:0]            new_exp_ff;

   // Output register.
   logic        rsp_valid_ff;
   logic [3:0]  rsp_id_ff;
   logic [47:0] rsp_time_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         now_ff <= '0;
      end else if (cmd.add_now) begin
         now_ff <= now_ff + TB'(elapsed_ff);
      end
   end

   // Latch the entry to place: a new start or the fired head.
   always_ff @(posedge clock) begin
      if (cmd.mul_req) begin
         new_slot_ff <= req_slot;
         new_per_ff  <= period_ff;
         base_ff     <= now_ff;
         prod_ff     <= ptq_pkg::PROD_BITS'(period_ff) *
                        ptq_pkg::PROD_BITS'(ptq_pkg::US_PER_MS);
      end else if (cmd.fire) begin
         new_slot_ff <= slot_ff[0];
         new_per_ff  <= per_ff[0];
         base_ff     <= exp_ff[0];
         prod_ff     <= ptq_pkg::PROD_BITS'(per_ff[0]) *
                        ptq_pkg::PROD_BITS'(ptq_pkg::US_PER_MS);
      end
      if (cmd.add_exp) begin
         new_exp_ff <= base_ff + TB'(prod_ff);
      end
   end

   // Chain update: insert behind equal or earlier expiries, or unlink a slot.
   logic [N-1:0]  keep;
   logic [N-1:0]  past;
   logic [IB-1:0] rm_slot;
   always_comb begin
      logic ge;
      logic hit;
      count_in = count_ff;
      armed_in = armed_ff;
      rm_slot  = cmd.fire ? slot_ff[0] : req_slot;
      for (int i = 0; i < N; i++) begin
         slot_in[i] = slot_ff[i];
         exp_in[i]  = exp_ff[i];
         per_in[i]  = per_ff[i];
      end
      for (int i = 0; i < N; i++) begin
         ge  = (CB'(i) < count_ff) && ptq_pkg::at_or_after(new_exp_ff, exp_ff[i]);
         hit = (CB'(i) < count_ff) && (slot_ff[i] == rm_slot);
         keep[i] = (i == 0) ? ge : (keep[i-1] && ge);
         past[i] = (i == 0) ? hit : (past[i-1] || hit);
      end
      if (cmd.insert && (count_ff < CB'(N))) begin
         for (int i = 0; i < N; i++) begin
            if (!keep[i]) begin
               if ((i == 0) || keep[(i == 0) ? 0 : i-1]) begin
                  slot_in[i] = new_slot_ff;
                  exp_in[i]  = new_exp_ff;
                  per_in[i]  = new_per_ff;
               end else begin
                  slot_in[i] = slot_ff[(i == 0) ? 0 : i-1];
                  exp_in[i]  = exp_ff[(i == 0) ? 0 : i-1];
                  per_in[i]  = per_ff[(i == 0) ? 0 : i-1];
               end
            end
         end
         count_in = count_ff + CB'(1);
      end else if ((cmd.remove || cmd.fire) && past[N-1]) begin
         for (int i = 0; i < N - 1; i++) begin
            if (past[i]) begin
               slot_in[i] = slot_ff[i+1];
               exp_in[i]  = exp_ff[i+1];
               per_in[i]  = per_ff[i+1];
            end
         end
         count_in = count_ff - CB'(1);
      end
      if (cmd.mul_req) armed_in[req_slot] = 1'b1;
      if (cmd.clr_armed) armed_in[req_slot] = 1'b0;
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < N; i++) begin
         slot_ff[i] <= slot_in[i];
         exp_ff[i]  <= exp_in[i];
         per_ff[i]  <= per_in[i];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         armed_ff <= '0;
      end else begin
         count_ff <= count_in;
         armed_ff <= armed_in;
      end
   end

   // Output register holds a fired beat until the receiver takes it.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.fire) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.fire) begin
         rsp_id_ff   <= 4'(slot_ff[0]);
         rsp_time_ff <= 48'(exp_ff[0]);
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_fired_timer = rsp_id_ff;
   assign rsp_fire_time   = rsp_time_ff;

   // Status toward the controller.
   always_comb begin
      status.command  = ptq_pkg::command_type'(cmd_ff);
      status.start_ok = id_in_range && !armed_ff[req_slot];
      status.stop_ok  = id_in_range && armed_ff[req_slot];
      status.head_due = (count_ff != '0) && ptq_pkg::at_or_after(now_ff, exp_ff[0]);
      status.rsp_busy = rsp_valid_ff && !rsp_ready;
      status.count    = count_ff;
      status.armed    = armed_ff;
   end

endmodule

>>> sim/ptq_timer_checker.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ptq_timer_checker: expiry predictor and result checker for the timer queue
// Watches both channels at the rising edge. Every accepted command beat
// updates a private sorted list of armed timers; a firing tick queues the
// slot and expiry it should emit, and each result beat is compared with the
// oldest entry of that queue.
// ---------------------------------------------------------------------------
module ptq_timer_checker
   import ptq_pkg::*;
(
   input logic       clock,
   input logic       reset,
   ptq_req_if.sink   req_mon,
   ptq_rsp_if.sink   rsp_mon,
   output int        error_count,
   output int        pending_fires
);

   typedef struct packed {
      logic [3:0]  slot;
      logic [47:0] fire_at;
   } fire_type;

   logic [TIME_BITS-1:0] clock_now;
   logic [TIME_BITS-1:0] due_at [NUM_TIMERS];
   logic [31:0]          period_ms_of [NUM_TIMERS];
   logic                 running [NUM_TIMERS];
   int unsigned          sorted_slots [$];
   fire_type             expected_fires [$];

   assign pending_fires = expected_fires.size();

   // Wrap-aware ordering of two times.
   function automatic bit not_before(logic [TIME_BITS-1:0] a, logic [TIME_BITS-1:0] b);
      logic [TIME_BITS-1:0] d;
      d = a - b;
      return !d[TIME_BITS-1];
   endfunction

   // Place a slot behind every timer with an equal or earlier expiry.
   task automatic place_slot(int unsigned slot);
      int pos;
      pos = 0;
      while (pos < sorted_slots.size() && not_before(due_at[slot], due_at[sorted_slots[pos]]))
         pos++;
      sorted_slots.insert(pos, slot);
   endtask

   task automatic unlink_slot(int unsigned slot);
      for (int i = 0; i < sorted_slots.size(); i++) begin
         if (sorted_slots[i] == slot) begin
            sorted_slots.delete(i);
            break;
         end
      end
   endtask

   // Apply one command beat and queue the fire that it causes, if any.
   task automatic apply_command(command_type cmd, logic [3:0] id, logic [31:0] per,
                                logic [15:0] elapsed);
      int unsigned head;
      fire_type f;
      case (cmd)
         CMD_START: begin
            if (!running[id]) begin
               due_at[id] = clock_now + TIME_BITS'(per) * US_PER_MS;
               period_ms_of[id] = per;
               running[id] = 1'b1;
               place_slot(id);
            end
         end
         CMD_STOP: begin
            if (running[id]) begin
               unlink_slot(id);
               running[id] = 1'b0;
            end
         end
         CMD_TICK: begin
            clock_now = clock_now + TIME_BITS'(elapsed);
            if (sorted_slots.size() > 0) begin
               head = sorted_slots[0];
               if (not_before(clock_now, due_at[head])) begin
                  f.slot = 4'(head);
                  f.fire_at = due_at[head];
                  expected_fires.push_back(f);
                  void'(sorted_slots.pop_front());
                  due_at[head] = due_at[head] + TIME_BITS'(period_ms_of[head]) * US_PER_MS;
                  place_slot(head);
               end
            end
         end
         default: ;
      endcase
   endtask

   always @(posedge clock) begin
      fire_type want;
      if (reset) begin
         clock_now = '0;
         sorted_slots.delete();
         expected_fires.delete();
         for (int i = 0; i < NUM_TIMERS; i++) running[i] = 1'b0;
         error_count = 0;
      end else begin
         // Compare a result beat before the same edge's command beat is applied.
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (expected_fires.size() == 0) begin
               error_count++;
               if (error_count <= 10)
                  $display("Unexpected fire beat: slot %0d time %0d",
                           rsp_mon.fired_timer, rsp_mon.fire_time);
            end else begin
               want = expected_fires.pop_front();
               if (want.slot !== rsp_mon.fired_timer || want.fire_at !== rsp_mon.fire_time) begin
                  error_count++;
                  if (error_count <= 10)
                     $display("Fire mismatch: expected slot %0d time %0d, got slot %0d time %0d",
                              want.slot, want.fire_at, rsp_mon.fired_timer,
                              rsp_mon.fire_time);
               end
            end
         end
         if (req_mon.valid && req_mon.ready)
            apply_command(command_type'(req_mon.command), req_mon.timer_id,
                          req_mon.period_ms, req_mon.elapsed_us);
      end
   end

endmodule

>>> sim/tb_top.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_top: stimulus and verdict for the periodic timer queue
// Drives directed and random start, stop and tick beats through several
// idle and stall phases; the checker predicts and compares the fire beats.
// ---------------------------------------------------------------------------
module tb_top;
   import ptq_pkg::*;

   logic clock;
   logic reset;
   int   error_count;
   int   pending_fires;
   int   send_idle_pct;
   int   recv_stall_pct;

   ptq_req_if req_bus ();
   ptq_rsp_if rsp_bus ();

   periodic_timer_queue i_dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus.sink),
      .rsp_bus (rsp_bus.source)
   );

   ptq_timer_checker i_checker (
      .clock         (clock),
      .reset         (reset),
      .req_mon       (req_bus.sink),
      .rsp_mon       (rsp_bus.sink),
      .error_count   (error_count),
      .pending_fires (pending_fires)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // Receiver stalls at random, changing at the falling edge.
   always @(negedge clock)
      rsp_bus.ready <= ($urandom_range(99) >= recv_stall_pct);

   // Send one beat; valid stays high until the beat is taken. The block is
   // busy after each accepted beat, so valid drops between beats.
   task automatic send_beat(command_type cmd, logic [3:0] id, logic [31:0] per,
                            logic [15:0] elapsed);
      while ($urandom_range(99) < send_idle_pct) @(negedge clock);
      req_bus.valid      <= 1'b1;
      req_bus.command    <= cmd;
      req_bus.timer_id   <= id;
      req_bus.period_ms  <= per;
      req_bus.elapsed_us <= elapsed;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      @(negedge clock);
      req_bus.valid <= 1'b0;
      @(negedge clock);
   endtask

   // Mostly short periods so that timers actually fire; a few full-range ones.
   function automatic logic [31:0] pick_period();
      case ($urandom_range(9))
         0:       return $urandom();
         1:       return 32'd0;
         default: return $urandom_range(40);
      endcase
   endfunction

   task automatic random_beat();
      int r;
      r = $urandom_range(99);
      if (r < 30)
         send_beat(CMD_START, 4'($urandom_range(15)), pick_period(), 16'($urandom()));
      else if (r < 42)
         send_beat(CMD_STOP, 4'($urandom_range(15)), $urandom(), 16'($urandom()));
      else if (r < 97)
         send_beat(CMD_TICK, 4'($urandom()), $urandom(),
                   ($urandom_range(3) == 0) ? 16'($urandom()) : 16'($urandom_range(20000)));
      else
         send_beat(CMD_NONE, 4'($urandom()), $urandom(), 16'($urandom()));
   endtask

   task automatic wait_drained();
      while (pending_fires != 0) @(negedge clock);
   endtask

   initial begin
      #40000000;
      $display("RESULT: ERROR");
      $finish;
   end

   initial begin
      reset = 1'b1;
      send_idle_pct = 0;
      recv_stall_pct = 0;
      req_bus.valid = 1'b0;
      req_bus.command = CMD_NONE;
      req_bus.timer_id = '0;
      req_bus.period_ms = '0;
      req_bus.elapsed_us = '0;
      rsp_bus.ready = 1'b0;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed: field extremes, every command, ignored and zero-period cases.
      send_beat(CMD_START, 4'd0, 32'd0, 16'hFFFF);
      send_beat(CMD_START, 4'd15, 32'hFFFF_FFFF, 16'd0);
      send_beat(CMD_START, 4'd5, 32'd1, 16'd0);
      send_beat(CMD_START, 4'd6, 32'd1, 16'd0);
      send_beat(CMD_START, 4'd5, 32'd7, 16'd0);
      send_beat(CMD_TICK, 4'd0, 32'd0, 16'd0);
      send_beat(CMD_TICK, 4'd15, 32'hFFFF_FFFF, 16'd0);
      send_beat(CMD_STOP, 4'd0, 32'd0, 16'd0);
      send_beat(CMD_STOP, 4'd0, 32'd0, 16'd0);
      send_beat(CMD_STOP, 4'd9, 32'd0, 16'd0);
      send_beat(CMD_TICK, 4'd0, 32'd0, 16'd999);
      send_beat(CMD_TICK, 4'd0, 32'd0, 16'd1);
      send_beat(CMD_TICK, 4'd0, 32'd0, 16'd1000);
      send_beat(CMD_TICK, 4'd0, 32'd0, 16'hFFFF);
      send_beat(CMD_NONE, 4'd15, 32'hFFFF_FFFF, 16'hFFFF);
      send_beat(CMD_STOP, 4'd15, 32'hFFFF_FFFF, 16'hFFFF);
      send_beat(CMD_STOP, 4'd5, 32'd0, 16'd0);
      send_beat(CMD_STOP, 4'd6, 32'd0, 16'd0);
      send_beat(CMD_START, 4'd3, 32'd0, 16'd0);
      send_beat(CMD_TICK, 4'd0, 32'd0, 16'd0);
      send_beat(CMD_TICK, 4'd0, 32'd0, 16'd0);
      send_beat(CMD_STOP, 4'd3, 32'd0, 16'd0);
      // Hold off until every fire so far has come out.
      wait_drained();

      // Random phases: none, sender idle, receiver stalls, both.
      for (int phase = 0; phase < 4; phase++) begin
         send_idle_pct  = (phase == 1 || phase == 3) ? ((phase == 3) ? 13 : 67) : 0;
         recv_stall_pct = (phase == 2 || phase == 3) ? ((phase == 3) ? 13 : 67) : 0;
         repeat (457) random_beat();
      end

      // About 1,000 ticks of at most 65535 us and periods below 2^32 ms keep
      // the time far below 2^47, so the count does not wrap in this run.
      wait_drained();
      repeat (20) @(posedge clock);
      wait_drained();
      if (error_count == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

endmodule
